>>> sv/bpf_alu_constant_propagation_assert.svh
// Assertion macros for the tagged eBPF ALU block.
// Used by bpf_alu_constant_propagation.sv; expects clk and rst_n in scope.
`ifndef BPF_ALU_CONSTANT_PROPAGATION_ASSERT_SVH
`define BPF_ALU_CONSTANT_PROPAGATION_ASSERT_SVH

// Property checked only outside reset.
`define BPFACP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BPFACP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bpfacp_pkg.sv
// Shared constants and types for the tagged eBPF ALU block.
// No dependencies.
package bpfacp_pkg;

    // Type tags.
    localparam logic [2:0] TAG_NOINIT  = 3'd0;
    localparam logic [2:0] TAG_UNKNOWN = 3'd1;
    localparam logic [2:0] TAG_BOTTOM  = 3'd2;
    localparam logic [2:0] TAG_NUMBER  = 3'd3;

    // Instruction classes.
    localparam logic [2:0] CLS_ALU   = 3'd4;
    localparam logic [2:0] CLS_ALU64 = 3'd7;

    // Operation codes from the upper nibble of the opcode.
    localparam logic [3:0] K_ADD = 4'h0;
    localparam logic [3:0] K_SUB = 4'h1;
    localparam logic [3:0] K_MUL = 4'h2;
    localparam logic [3:0] K_DIV = 4'h3;
    localparam logic [3:0] K_OR  = 4'h4;
    localparam logic [3:0] K_AND = 4'h5;
    localparam logic [3:0] K_LSH = 4'h6;
    localparam logic [3:0] K_RSH = 4'h7;
    localparam logic [3:0] K_NEG = 4'h8;
    localparam logic [3:0] K_MOD = 4'h9;
    localparam logic [3:0] K_XOR = 4'hA;
    localparam logic [3:0] K_MOV = 4'hB;
    localparam logic [3:0] K_ARSH = 4'hC;
    localparam logic [3:0] K_END = 4'hD;

    // Divider steps, one per pipeline stage, and total stages before the output.
    localparam int DIV_STEPS = 64;
    localparam int NST       = DIV_STEPS + 2;

    // Payload carried by every pipeline stage.
    typedef struct packed {
        logic [3:0]  kind;
        logic        be;
        logic        is64;
        logic [2:0]  rtype;
        logic        bad;
        logic        use_val;
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] bm;
        logic [5:0]  cnt;
        logic [63:0] simple;
        logic [63:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [63:0] prod;
        logic        dvz;
        logic [63:0] rem;
        logic [63:0] quo;
    } pl_t;

endpackage

>>> sv/bpfacp_ifs.sv
// Valid/ready channel interfaces for the tagged eBPF ALU block.
// No dependencies.
interface bpfacp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opcode;
    logic signed [31:0] imm;
    logic [2:0]  dst_type;
    logic [63:0] dst_value;
    logic [2:0]  src_type;
    logic [63:0] src_value;

    modport source (output valid, opcode, imm, dst_type, dst_value, src_type, src_value,
                    input ready);
    modport sink (input valid, opcode, imm, dst_type, dst_value, src_type, src_value,
                  output ready);
endinterface

interface bpfacp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_type;
    logic [63:0] result_value;
    logic        bad_opcode;

    modport source (output valid, result_type, result_value, bad_opcode, input ready);
    modport sink (input valid, result_type, result_value, bad_opcode, output ready);
endinterface

>>> sv/bpf_alu_constant_propagation.sv
// Top level of the tagged eBPF ALU block: decode, datapath and divider pipeline.
// Depends on bpfacp_pkg, bpfacp_ifs.sv and bpf_alu_constant_propagation_assert.svh.
//
// Usage: one item on req carries an opcode byte, an immediate and the tagged
// destination and source operands. One item on rsp carries the result tag,
// the result value and a flag for opcodes that are not ALU operations.
// Every input item gives exactly one result item, in order.
// Every item passes, in order, one decode stage, one stage for the simple
// operations and the partial products of the multiplier, 64 stages of the
// restoring divider (one quotient bit per stage, the multiplier sum rides in
// the first), and the output register, from acceptance on req to rsp.
// Throughput is one item per cycle while rsp does not stall; every item passes the divider stages.
// The whole pipeline advances together; when rsp stalls with a result
// waiting, req.ready drops and every stage holds, so nothing is lost.
// Reset clears the valid bits of all stages and of the output register.
`include "bpf_alu_constant_propagation_assert.svh"

module bpf_alu_constant_propagation
    import bpfacp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bpfacp_in_if.sink    req,
    bpfacp_out_if.source rsp
);

    // Type rule; the first matching case wins.
    function automatic logic [2:0] type_rule(input logic [3:0] kind, input logic [2:0] dt,
                                             input logic [2:0] st, input logic rs);
        logic [2:0] t;
        begin
            if (kind == K_MOV && !rs)
                t = TAG_NUMBER;
            else if (rs && st == TAG_NOINIT)
                t = TAG_BOTTOM;
            else if (kind == K_MOV)
                t = st;
            else if (dt == TAG_NOINIT)
                t = TAG_BOTTOM;
            else if (dt == TAG_UNKNOWN)
                t = TAG_UNKNOWN;
            else if ((kind == K_ADD || kind == K_SUB) && !rs)
                t = dt;
            else if (kind == K_ADD)
            begin
                if (dt != TAG_NUMBER && st == TAG_NUMBER)
                    t = dt;
                else if (st != TAG_NUMBER && dt == TAG_NUMBER)
                    t = st;
                else
                    t = TAG_UNKNOWN;
            end
            else if (kind == K_SUB)
                t = (st == dt) ? TAG_NUMBER : TAG_UNKNOWN;
            else
                t = (dt == TAG_NUMBER && (!rs || st == TAG_NUMBER)) ? TAG_NUMBER : TAG_UNKNOWN;
            return t;
        end
    endfunction

    // Byte swap of the low 32 bits.
    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    logic adv;
    logic vld_reg [NST];
    pl_t  pl_reg  [NST];
    pl_t  pl_next [NST];
    logic out_vld_reg;
    logic [2:0]  out_type_reg, out_type_next;
    logic [63:0] out_val_reg, out_val_next;
    logic        out_bad_reg;

    // The pipeline moves as one whenever the output register is empty or rsp takes its result.
    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    // Decode of the incoming item.
    always_comb
    begin
        logic [2:0]  cls;
        logic [3:0]  kind;
        logic        ok;
        logic        rs;
        logic        is64;
        logic [63:0] b;
        logic [63:0] m;
        cls  = req.opcode[2:0];
        kind = req.opcode[7:4];
        if (cls != CLS_ALU && cls != CLS_ALU64)
            ok = 1'b0;
        else if (kind <= K_ARSH)
            ok = !(kind == K_NEG && req.opcode[3]);
        else
            ok = (kind == K_END) && (cls == CLS_ALU);
        is64 = (cls == CLS_ALU64);
        rs   = req.opcode[3] && (kind != K_END);
        b    = rs ? req.src_value : {{32{req.imm[31]}}, req.imm};
        m    = is64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        pl_next[0]         = '0;
        pl_next[0].kind    = kind;
        pl_next[0].be      = req.opcode[3];
        pl_next[0].is64    = is64;
        pl_next[0].bad     = !ok;
        pl_next[0].rtype   = ok ? type_rule(kind, req.dst_type, req.src_type, rs) : TAG_BOTTOM;
        pl_next[0].use_val = ok && (pl_next[0].rtype >= TAG_NUMBER);
        pl_next[0].d       = req.dst_value;
        pl_next[0].a       = req.dst_value & m;
        pl_next[0].bm      = b & m;
        pl_next[0].cnt     = is64 ? b[5:0] : {1'b0, b[4:0]};
    end

    // Simple operations, multiplier partial products and divider setup.
    always_comb
    begin
        pl_t p;
        logic [31:0] sh32;
        p = pl_reg[0];
        sh32 = $unsigned($signed(p.a[31:0]) >>> p.cnt[4:0]);
        unique case (p.kind)
            K_ADD:  p.simple = p.a + p.bm;
            K_SUB:  p.simple = p.a - p.bm;
            K_OR:   p.simple = p.a | p.bm;
            K_AND:  p.simple = p.a & p.bm;
            K_LSH:  p.simple = p.a << p.cnt;
            K_RSH:  p.simple = p.a >> p.cnt;
            K_NEG:  p.simple = 64'd0 - p.a;
            K_XOR:  p.simple = p.a ^ p.bm;
            K_MOV:  p.simple = p.bm;
            K_ARSH: p.simple = p.is64 ? $unsigned($signed(p.a) >>> p.cnt) : {32'd0, sh32};
            K_END:
            begin
                // Little endian only truncates; big endian swaps.
                p.simple = p.d;
                if (!p.be)
                begin
                    if (p.bm == 64'd16)
                        p.simple = {48'd0, p.d[15:0]};
                    else if (p.bm == 64'd32)
                        p.simple = {32'd0, p.d[31:0]};
                end
                else
                begin
                    if (p.bm == 64'd16)
                        p.simple = {48'd0, p.d[7:0], p.d[15:8]};
                    else if (p.bm == 64'd32)
                        p.simple = {32'd0, bswap32(p.d[31:0])};
                    else if (p.bm == 64'd64)
                        p.simple = {bswap32(p.d[31:0]), bswap32(p.d[63:32])};
                end
            end
            default: p.simple = p.a;
        endcase
        p.p0  = p.a[31:0] * p.bm[31:0];
        p.p1  = 32'(p.a[31:0] * p.bm[63:32]);
        p.p2  = 32'(p.a[63:32] * p.bm[31:0]);
        p.dvz = (p.bm == 64'd0);
        p.rem = 64'd0;
        p.quo = p.a;
        pl_next[1] = p;
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_comb
        begin
            pl_t p;
            logic [64:0] r1;
            p  = pl_reg[k+1];
            r1 = {p.rem, p.quo[63]};
            if (r1 >= {1'b0, p.bm})
            begin
                r1    = r1 - {1'b0, p.bm};
                p.quo = {p.quo[62:0], 1'b1};
            end
            else
                p.quo = {p.quo[62:0], 1'b0};
            p.rem = r1[63:0];
            if (k == 0)
                p.prod = p.p0 + {p.p1 + p.p2, 32'd0};
            pl_next[k+2] = p;
        end
    end

    // Stage registers: valid bits reset, payload does not.
    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= (k == 0) ? req.valid : vld_reg[(k == 0) ? 0 : k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                pl_reg[k] <= pl_next[k];
        end
    end

    // Final result selection.
    always_comb
    begin
        pl_t p;
        logic [63:0] r;
        logic [63:0] m;
        p = pl_reg[NST-1];
        m = p.is64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        unique case (p.kind)
            K_MUL:   r = p.prod & m;
            K_DIV:   r = p.dvz ? 64'd0 : (p.quo & m);
            K_MOD:   r = p.dvz ? p.a : (p.rem & m);
            K_END:   r = p.simple;
            default: r = p.simple & m;
        endcase
        out_type_next = p.rtype;
        out_val_next  = p.use_val ? r : p.d;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_type_reg <= out_type_next;
            out_val_reg  <= out_val_next;
            out_bad_reg  <= pl_reg[NST-1].bad;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.result_type  = out_type_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.bad_opcode   = out_bad_reg;

    // Checks on the pipeline.
    `BPFACP_ASSERT(a_last_to_out, adv && vld_reg[NST-1] |=> out_vld_reg, "item lost at output")
    `BPFACP_ASSERT(a_rem_bound, vld_reg[NST-1] && !pl_reg[NST-1].dvz |-> pl_reg[NST-1].rem < pl_reg[NST-1].bm, "divider remainder out of range")
    `BPFACP_ASSERT(a_bad_bottom, out_vld_reg && out_bad_reg |-> out_type_reg == TAG_BOTTOM, "bad opcode without bottom tag")
    `BPFACP_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_vld_reg, "output valid during reset")

endmodule

>>> tb/tb_bpf_alu_constant_propagation.sv
// Self-checking testbench for the tagged eBPF ALU block.
// Depends on bpfacp_pkg, bpfacp_ifs.sv and bpf_alu_constant_propagation.sv.
module tb_bpf_alu_constant_propagation;
    import bpfacp_pkg::*;

    localparam int LATENCY = 67;
    localparam int N_RANDOM = 1200;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [31:0] imm;
        logic [2:0]  dst_type;
        logic [63:0] dst_value;
        logic [2:0]  src_type;
        logic [63:0] src_value;
    } alu_item_t;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [63:0] rvalue;
        logic        bad;
    } alu_result_t;

    // Directed row: an instruction and, where known at a glance, its result.
    typedef struct {
        alu_item_t   item;
        bit          typed;
        alu_result_t res;
    } row_t;

    logic clk;
    logic rst_n;
    bpfacp_in_if  req();
    bpfacp_out_if rsp();

    alu_result_t expected_q[$];
    int errors;
    bit stim_done;
    bit hold_off;

    bpf_alu_constant_propagation u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Clock, period 4.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Opcode legality per the standard ALU encoding.
    function automatic bit legal_op(logic [7:0] op);
        if (op[2:0] != CLS_ALU && op[2:0] != CLS_ALU64)
            return 1'b0;
        if (op[7:4] <= K_ARSH)
            return !(op[7:4] == K_NEG && op[3]);
        return op == {K_END, 1'b0, CLS_ALU} || op == {K_END, 1'b1, CLS_ALU};
    endfunction

    function automatic logic [2:0] tag_of(logic [3:0] kind, logic [2:0] dt,
                                          logic [2:0] st, bit reads_src);
        if (kind == K_MOV && !reads_src)
            return TAG_NUMBER;
        if (reads_src && st == TAG_NOINIT)
            return TAG_BOTTOM;
        if (kind == K_MOV)
            return st;
        if (dt == TAG_NOINIT)
            return TAG_BOTTOM;
        if (dt == TAG_UNKNOWN)
            return TAG_UNKNOWN;
        if ((kind == K_ADD || kind == K_SUB) && !reads_src)
            return dt;
        if (kind == K_ADD)
        begin
            if (dt != TAG_NUMBER && st == TAG_NUMBER)
                return dt;
            if (st != TAG_NUMBER && dt == TAG_NUMBER)
                return st;
            return TAG_UNKNOWN;
        end
        if (kind == K_SUB)
            return (st == dt) ? TAG_NUMBER : TAG_UNKNOWN;
        return (dt == TAG_NUMBER && (!reads_src || st == TAG_NUMBER)) ? TAG_NUMBER
                                                                     : TAG_UNKNOWN;
    endfunction

    function automatic logic [31:0] swap32(logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Predicts the tagged result of one instruction.
    function automatic alu_result_t evaluate_alu(alu_item_t it);
        alu_result_t r;
        logic [3:0]  kind;
        logic [63:0] simm, b, m, a, bm, v, d;
        bit is64, reads_src;
        int cnt, bits;
        kind = it.opcode[7:4];
        d = it.dst_value;
        simm = {{32{it.imm[31]}}, it.imm};
        r.rtype = TAG_BOTTOM;
        r.rvalue = d;
        r.bad = 1'b1;
        if (!legal_op(it.opcode))
            return r;
        r.bad = 1'b0;
        is64 = it.opcode[2:0] == CLS_ALU64;
        reads_src = it.opcode[3] && kind != K_END;
        r.rtype = tag_of(kind, it.dst_type, it.src_type, reads_src);
        if (r.rtype == TAG_UNKNOWN || r.rtype == TAG_NOINIT || r.rtype == TAG_BOTTOM)
            return r;
        b = reads_src ? it.src_value : simm;
        m = is64 ? '1 : 64'hFFFF_FFFF;
        bits = is64 ? 64 : 32;
        cnt = int'(b & (bits - 1));
        a = d & m;
        bm = b & m;
        case (kind)
            K_ADD: v = a + bm;
            K_SUB: v = a - bm;
            K_MUL: v = a * bm;
            K_DIV: v = (bm == 0) ? 64'd0 : a / bm;
            K_OR:  v = a | bm;
            K_AND: v = a & bm;
            K_LSH: v = a << cnt;
            K_RSH: v = a >> cnt;
            K_NEG: v = 64'd0 - a;
            K_MOD: v = (bm == 0) ? a : a % bm;
            K_XOR: v = a ^ bm;
            K_MOV: v = bm;
            K_ARSH:
            begin
                if (is64)
                    v = $signed(a) >>> cnt;
                else
                    v = {32'd0, 32'($signed(a[31:0]) >>> cnt)};
            end
            default:
            begin
                // Byte swaps ignore the mask; unknown widths leave dst alone.
                v = d;
                if (!it.opcode[3])
                begin
                    if (simm == 64'd16)
                        v = d & 64'hFFFF;
                    else if (simm == 64'd32)
                        v = d & 64'hFFFF_FFFF;
                end
                else
                begin
                    if (simm == 64'd16)
                        v = {48'd0, d[7:0], d[15:8]};
                    else if (simm == 64'd32)
                        v = {32'd0, swap32(d[31:0])};
                    else if (simm == 64'd64)
                        v = {swap32(d[31:0]), swap32(d[63:32])};
                end
                r.rvalue = v;
                return r;
            end
        endcase
        r.rvalue = v & m;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 70));
            3: return {32'd0, 32'($urandom)};
            4: return {1'b1, 63'd0} >> $urandom_range(0, 63);
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic alu_item_t random_item();
        alu_item_t it;
        logic [3:0] kind;
        it.dst_value = rand64();
        it.src_value = rand64();
        it.dst_type = ($urandom_range(0, 3) == 0) ? 3'($urandom) : TAG_NUMBER;
        it.src_type = ($urandom_range(0, 3) == 0) ? 3'($urandom) : TAG_NUMBER;
        case ($urandom_range(0, 3))
            0: it.imm = 32'($urandom_range(0, 70));
            1: it.imm = 32'($urandom);
            2: it.imm = {16{2'($urandom)}};
            default: it.imm = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        endcase
        if ($urandom_range(0, 9) == 0)
            it.opcode = 8'($urandom);
        else
        begin
            kind = 4'($urandom_range(0, 13));
            it.opcode = {kind, 1'($urandom),
                         ($urandom_range(0, 1) != 0) ? CLS_ALU64 : CLS_ALU};
            if (kind == K_END)
            begin
                it.opcode[2:0] = CLS_ALU;
                if ($urandom_range(0, 1) != 0)
                    it.imm = 32'(16 << $urandom_range(0, 2));
            end
        end
        return it;
    endfunction

    function automatic alu_item_t mk(logic [7:0] op, logic [31:0] imm, logic [2:0] dt,
                                     logic [63:0] dv, logic [2:0] st, logic [63:0] sv);
        alu_item_t it;
        it.opcode = op;
        it.imm = imm;
        it.dst_type = dt;
        it.dst_value = dv;
        it.src_type = st;
        it.src_value = sv;
        return it;
    endfunction

    // Drives one item and waits for its acceptance; valid drops only during a gap.
    task automatic send_item(alu_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= it.opcode;
        req.imm <= it.imm;
        req.dst_type <= it.dst_type;
        req.dst_value <= it.dst_value;
        req.src_type <= it.src_type;
        req.src_value <= it.src_value;
        do
            @(posedge clk);
        while (!req.ready);
        expected_q.push_back(evaluate_alu(it));
    endtask

    // Stimulus: directed table, then random instructions.
    initial
    begin
        row_t rows[$];
        row_t rw;
        alu_item_t it;
        errors = 0;
        stim_done = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.imm = '0;
        req.dst_type = '0;
        req.dst_value = '0;
        req.src_type = '0;
        req.src_value = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        rw.typed = 1'b1;
        // Bad opcodes: wrong class, NEG with the source bit, swap on ALU64, unknown operation.
        rw.item = mk(8'h00, '0, TAG_NUMBER, '1, TAG_NUMBER, '0);
        rw.res = '{TAG_BOTTOM, '1, 1'b1};
        rows.push_back(rw);
        rw.item = mk({K_NEG, 1'b1, CLS_ALU64}, '0, TAG_NUMBER, 64'd5, TAG_NUMBER, '0);
        rw.res = '{TAG_BOTTOM, 64'd5, 1'b1};
        rows.push_back(rw);
        rw.item = mk({K_END, 1'b1, CLS_ALU64}, 32'd64, TAG_NUMBER, 64'd7, TAG_NUMBER, '0);
        rw.res = '{TAG_BOTTOM, 64'd7, 1'b1};
        rows.push_back(rw);
        rw.item = mk(8'hFF, '1, 3'd7, '1, 3'd7, '1);
        rw.res = '{TAG_BOTTOM, '1, 1'b1};
        rows.push_back(rw);
        // Divide by zero gives zero; modulo by zero keeps the low dst bits.
        rw.item = mk({K_DIV, 1'b1, CLS_ALU64}, '0, TAG_NUMBER, '1, TAG_NUMBER, '0);
        rw.res = '{TAG_NUMBER, '0, 1'b0};
        rows.push_back(rw);
        rw.item = mk({K_MOD, 1'b0, CLS_ALU}, '0, TAG_NUMBER, '1, TAG_NUMBER, '0);
        rw.res = '{TAG_NUMBER, 64'hFFFF_FFFF, 1'b0};
        rows.push_back(rw);
        // Uninitialized source and destination give bottom; unknown stays.
        rw.item = mk({K_ADD, 1'b1, CLS_ALU64}, '0, TAG_NUMBER, 64'd9, TAG_NOINIT, '1);
        rw.res = '{TAG_BOTTOM, 64'd9, 1'b0};
        rows.push_back(rw);
        rw.item = mk({K_OR, 1'b0, CLS_ALU64}, '1, TAG_NOINIT, 64'd3, TAG_NUMBER, '0);
        rw.res = '{TAG_BOTTOM, 64'd3, 1'b0};
        rows.push_back(rw);
        rw.item = mk({K_XOR, 1'b0, CLS_ALU64}, '1, TAG_UNKNOWN, 64'd4, TAG_NUMBER, '0);
        rw.res = '{TAG_UNKNOWN, 64'd4, 1'b0};
        rows.push_back(rw);
        // MOV with the most negative immediate sign extends.
        rw.item = mk({K_MOV, 1'b0, CLS_ALU64}, 32'h8000_0000, TAG_NOINIT, '0, TAG_NOINIT, '0);
        rw.res = '{TAG_NUMBER, 64'hFFFF_FFFF_8000_0000, 1'b0};
        rows.push_back(rw);
        rw.typed = 1'b0;
        // Pointer arithmetic, shift masking, arithmetic shifts, a multiply, swaps, a negation.
        rows.push_back('{mk({K_ADD, 1'b1, CLS_ALU64}, '0, 3'd5, 64'd16, TAG_NUMBER, '1),
                         1'b0, '0});
        rows.push_back('{mk({K_ADD, 1'b1, CLS_ALU64}, '0, TAG_NUMBER, 64'd8, 3'd6, '0),
                         1'b0, '0});
        rows.push_back('{mk({K_SUB, 1'b1, CLS_ALU64}, '0, 3'd4, 64'd8, 3'd4, 64'd2),
                         1'b0, '0});
        rows.push_back('{mk({K_SUB, 1'b0, CLS_ALU}, '1, 3'd7, 64'd8, 3'd4, '0), 1'b0, '0});
        rows.push_back('{mk({K_MOV, 1'b1, CLS_ALU}, '0, '0, '0, 3'd7, '1), 1'b0, '0});
        rows.push_back('{mk({K_LSH, 1'b1, CLS_ALU}, '0, TAG_NUMBER, '1, TAG_NUMBER, 64'd33),
                         1'b0, '0});
        rows.push_back('{mk({K_ARSH, 1'b0, CLS_ALU}, 32'd31, TAG_NUMBER, 64'h8000_0000,
                            TAG_NUMBER, '0), 1'b0, '0});
        rows.push_back('{mk({K_ARSH, 1'b1, CLS_ALU64}, '0, TAG_NUMBER, '1 << 63,
                            TAG_NUMBER, 64'd127), 1'b0, '0});
        rows.push_back('{mk({K_MUL, 1'b1, CLS_ALU64}, '0, TAG_NUMBER, '1, TAG_NUMBER, '1),
                         1'b0, '0});
        rows.push_back('{mk({K_RSH, 1'b0, CLS_ALU}, 32'd65, TAG_NUMBER, '1, TAG_NUMBER, '0),
                         1'b0, '0});
        rows.push_back('{mk({K_END, 1'b1, CLS_ALU}, 32'd64, TAG_NUMBER,
                            64'h0123_4567_89AB_CDEF, '0, '0), 1'b0, '0});
        rows.push_back('{mk({K_END, 1'b0, CLS_ALU}, 32'd16, 3'd5, '1, '0, '0), 1'b0, '0});
        rows.push_back('{mk({K_END, 1'b1, CLS_ALU}, 32'd8, TAG_NUMBER, 64'd77, '0, '0),
                         1'b0, '0});
        rows.push_back('{mk({K_NEG, 1'b0, CLS_ALU}, '0, TAG_NUMBER, 64'd1, '0, '0), 1'b0, '0});

        foreach (rows[i])
        begin
            send_item(rows[i].item);
            // Typed rows check the predictor as well as the block.
            if (rows[i].typed && expected_q[$] !== rows[i].res)
            begin
                $display("%0t: table row %0d: expected %h, predicted %h", $time, i,
                         rows[i].res, expected_q[$]);
                errors++;
            end
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            it = random_item();
            if (n == 300)
                hold_off = 1'b1;
            send_item(it);
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver with random stalls and one long hold-off.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (200)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall)
                    @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result type %0d value %h bad %b", $time,
                         rsp.result_type, rsp.result_value, rsp.bad_opcode);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp.result_type !== want.rtype)
                begin
                    $display("%0t: result_type expected %0d actual %0d", $time,
                             want.rtype, rsp.result_type);
                    errors++;
                end
                if (rsp.result_value !== want.rvalue)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             want.rvalue, rsp.result_value);
                    errors++;
                end
                if (rsp.bad_opcode !== want.bad)
                begin
                    $display("%0t: bad_opcode expected %b actual %b", $time,
                             want.bad, rsp.bad_opcode);
                    errors++;
                end
            end
        end
    end

    // End of run once everything has drained.
    initial
    begin
        wait (stim_done && expected_q.size() == 0);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/bpfacp_pkg.sv
sv/bpfacp_ifs.sv
sv/bpf_alu_constant_propagation.sv
tb/tb_bpf_alu_constant_propagation.sv
